### sv/uscp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscp_pkg
// shared types and byte codes of the serial-to-spi bridge command parser
// ----------------------------------------------------------------------------
package uscp_pkg;

  // parse modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_SINGLE = 3'd1;
  localparam logic [2:0] MODE_LEN_LO = 3'd2;
  localparam logic [2:0] MODE_LEN_HI = 3'd3;
  localparam logic [2:0] MODE_BLOCK  = 3'd4;

  // host commands
  localparam logic [7:0] CMD_IDENT     = 8'h01;
  localparam logic [7:0] CMD_RESET_LO  = 8'h10;
  localparam logic [7:0] CMD_RESET_HI  = 8'h11;
  localparam logic [7:0] CMD_WREN      = 8'h20;
  localparam logic [7:0] CMD_SINGLE    = 8'h21;
  localparam logic [7:0] CMD_BLOCK     = 8'h22;
  localparam logic [7:0] CMD_SELECT_LO = 8'h23;
  localparam logic [7:0] CMD_SELECT_HI = 8'h24;

  // reply and flash bytes
  localparam logic [7:0] BYTE_IDENT = 8'h42;
  localparam logic [7:0] BYTE_ACK   = 8'h06;
  localparam logic [7:0] BYTE_NAK   = 8'h15;
  localparam logic [7:0] SPI_WREN   = 8'h06;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  length_low;
    logic [15:0] bytes_left;
    logic        select_reg;
    logic        reset_reg;
  } state_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       spi_valid;
    logic [7:0] spi_byte;
    logic       spi_framed;
    logic       select_level;
    logic       reset_level;
  } result_t;

endpackage
`default_nettype wire

### sv/uscp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscp_in_if
// command word channel: host byte plus flash return byte
// ----------------------------------------------------------------------------
interface uscp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [7:0] flash_reply;

  modport source (output valid, output rx_byte, output flash_reply, input ready);
  modport sink   (input valid, input rx_byte, input flash_reply, output ready);
endinterface
`default_nettype wire

### sv/uscp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscp_out_if
// result word channel: host reply, spi transfer and pin levels
// ----------------------------------------------------------------------------
interface uscp_out_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       spi_valid;
  logic [7:0] spi_byte;
  logic       spi_framed;
  logic       select_level;
  logic       reset_level;

  modport source (output valid, output reply_valid, output reply_byte, output spi_valid,
                  output spi_byte, output spi_framed, output select_level,
                  output reset_level, input ready);
  modport sink   (input valid, input reply_valid, input reply_byte, input spi_valid,
                  input spi_byte, input spi_framed, input select_level,
                  input reset_level, output ready);
endinterface
`default_nettype wire

### sv/uscp_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uscp_decode
// one-byte command decode: next parser state and the result word
// ----------------------------------------------------------------------------
module uscp_decode (
  input  wire uscp_pkg::state_t  state,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [7:0]        flash_reply,
  output uscp_pkg::state_t       state_next,
  output uscp_pkg::result_t      result
);

  logic [15:0] length_full;
  logic [15:0] left_dec;

  assign length_full = {rx_byte, state.length_low};
  assign left_dec    = state.bytes_left - 16'd1;

  always_comb begin
    state_next          = state;
    result.reply_valid  = 1'b0;
    result.reply_byte   = 8'h00;
    result.spi_valid    = 1'b0;
    result.spi_byte     = 8'h00;
    result.spi_framed   = 1'b0;

    case (state.mode)
      uscp_pkg::MODE_SINGLE: begin
        result.spi_valid   = 1'b1;
        result.spi_byte    = rx_byte;
        result.reply_valid = 1'b1;
        result.reply_byte  = flash_reply;
        state_next.mode    = uscp_pkg::MODE_IDLE;
      end
      uscp_pkg::MODE_LEN_LO: begin
        state_next.length_low = rx_byte;
        state_next.mode       = uscp_pkg::MODE_LEN_HI;
      end
      uscp_pkg::MODE_LEN_HI: begin
        state_next.bytes_left = length_full;
        // zero length falls straight back to idle
        state_next.mode = (length_full == 16'd0) ? uscp_pkg::MODE_IDLE
                                                 : uscp_pkg::MODE_BLOCK;
      end
      uscp_pkg::MODE_BLOCK: begin
        result.spi_valid      = 1'b1;
        result.spi_byte       = rx_byte;
        result.reply_valid    = 1'b1;
        result.reply_byte     = flash_reply;
        state_next.bytes_left = left_dec;
        if (left_dec == 16'd0) begin
          state_next.mode = uscp_pkg::MODE_IDLE;
        end
      end
      default: begin
        state_next.mode    = uscp_pkg::MODE_IDLE;
        result.reply_valid = 1'b1;
        result.reply_byte  = uscp_pkg::BYTE_ACK;
        case (rx_byte)
          uscp_pkg::CMD_IDENT:     result.reply_byte = uscp_pkg::BYTE_IDENT;
          uscp_pkg::CMD_RESET_LO:  state_next.reset_reg = 1'b0;
          uscp_pkg::CMD_RESET_HI:  state_next.reset_reg = 1'b1;
          uscp_pkg::CMD_WREN: begin
            result.spi_valid      = 1'b1;
            result.spi_byte       = uscp_pkg::SPI_WREN;
            result.spi_framed     = 1'b1;
            state_next.select_reg = 1'b1;
          end
          uscp_pkg::CMD_SINGLE: begin
            result.reply_valid = 1'b0;
            result.reply_byte  = 8'h00;
            state_next.mode    = uscp_pkg::MODE_SINGLE;
          end
          uscp_pkg::CMD_BLOCK: begin
            result.reply_valid = 1'b0;
            result.reply_byte  = 8'h00;
            state_next.mode    = uscp_pkg::MODE_LEN_LO;
          end
          uscp_pkg::CMD_SELECT_LO: state_next.select_reg = 1'b0;
          uscp_pkg::CMD_SELECT_HI: state_next.select_reg = 1'b1;
          default:                 result.reply_byte = uscp_pkg::BYTE_NAK;
        endcase
      end
    endcase

    result.select_level = state_next.select_reg;
    result.reset_level  = state_next.reset_reg;
  end

endmodule
`default_nettype wire

### sv/uart_spi_bridge_command_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// a result word is registered and appears in the cycle after its command word is accepted
// throughput: one word per cycle while the result side is ready; decode and the 16-bit count update sit
// between the parser state registers and the output register
// the output register frees itself in the cycle its word is taken downstream
// reset (rst, synchronous, active high): parser idle, counters zero,
// chip select deselected, fpga reset released, output register empty
// ----------------------------------------------------------------------------
// uart_spi_bridge_command_parser
// serial-to-spi bridge command parser: one host byte in, one result word out
// ----------------------------------------------------------------------------
module uart_spi_bridge_command_parser (
  input  wire logic   clk,
  input  wire logic   rst,
  uscp_in_if.sink     cmd,
  uscp_out_if.source  rsp
);

  // parser state, updated only when a command word is taken
  uscp_pkg::state_t  state;
  uscp_pkg::state_t  state_next;
  uscp_pkg::result_t result;

  // output register
  logic              out_valid;
  uscp_pkg::result_t out_word;

  logic cmd_take;

  // the output slot is free when empty or when its word leaves this cycle
  assign cmd.ready = !out_valid || rsp.ready;
  assign cmd_take  = cmd.valid && cmd.ready;

  uscp_decode u_decode (
    .state       (state),
    .rx_byte     (cmd.rx_byte),
    .flash_reply (cmd.flash_reply),
    .state_next  (state_next),
    .result      (result)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= uscp_pkg::MODE_IDLE;
      state.length_low <= 8'h00;
      state.bytes_left <= 16'h0000;
      state.select_reg <= 1'b1;
      state.reset_reg  <= 1'b1;
    end else if (cmd_take) begin
      state <= state_next;
    end
  end

  // result word register with valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_word <= result;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.reply_valid  = out_word.reply_valid;
  assign rsp.reply_byte   = out_word.reply_byte;
  assign rsp.spi_valid    = out_word.spi_valid;
  assign rsp.spi_byte     = out_word.spi_byte;
  assign rsp.spi_framed   = out_word.spi_framed;
  assign rsp.select_level = out_word.select_level;
  assign rsp.reset_level  = out_word.reset_level;

  // block mode always has bytes still to move
  a_block_count: assert property (@(posedge clk) disable iff (rst)
    state.mode == uscp_pkg::MODE_BLOCK |-> state.bytes_left != 16'd0)
    else $error("block mode with zero bytes left");

  // parser state moves only on a taken command word
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd_take |=> $stable(state))
    else $error("parser state changed without a command word");

  // a framed write-enable transfer leaves the chip deselected
  a_framed_desel: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.spi_framed |-> rsp.spi_valid && rsp.select_level)
    else $error("framed transfer without deselect");

  // a silent reply byte is zero
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.reply_valid |-> rsp.reply_byte == 8'h00)
    else $error("reply byte set without reply");

  // pins in the result track the parser state after its word
  a_pin_track: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> rsp.select_level == state.select_reg &&
                 rsp.reset_level == state.reset_reg)
    else $error("pin levels differ from parser state");

endmodule
`default_nettype wire

### verif/uart_spi_bridge_command_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_spi_bridge_command_parser_test
// drives host command bytes with random flash return bytes into the parser,
// predicts every result word from a model of the parse state, and compares
// each field of each result word in order; both channels stall at random
// ----------------------------------------------------------------------------
module uart_spi_bridge_command_parser_test;

  // tracks the parse state and holds the result words still to come
  class bridge_tracker;
    uscp_pkg::state_t  parser;
    uscp_pkg::result_t expected_words[$];
    int                fails;

    function new();
      parser.mode       = uscp_pkg::MODE_IDLE;
      parser.length_low = 8'h00;
      parser.bytes_left = 16'h0000;
      parser.select_reg = 1'b1;
      parser.reset_reg  = 1'b1;
      fails             = 0;
    endfunction

    task report(string what);
      fails++;
      $display("mismatch %0d at %0t: %s", fails, $realtime, what);
    endtask

    // advances the parse state by one host byte, returns the word it causes
    function uscp_pkg::result_t predict_word(logic [7:0] rx, logic [7:0] fr);
      uscp_pkg::result_t w;
      w = '0;
      case (parser.mode)
        uscp_pkg::MODE_SINGLE: begin
          w.spi_valid   = 1'b1;
          w.spi_byte    = rx;
          w.reply_valid = 1'b1;
          w.reply_byte  = fr;
          parser.mode   = uscp_pkg::MODE_IDLE;
        end
        uscp_pkg::MODE_LEN_LO: begin
          parser.length_low = rx;
          parser.mode       = uscp_pkg::MODE_LEN_HI;
        end
        uscp_pkg::MODE_LEN_HI: begin
          parser.bytes_left = {rx, parser.length_low};
          parser.mode = (parser.bytes_left == 16'h0000) ? uscp_pkg::MODE_IDLE
                                                        : uscp_pkg::MODE_BLOCK;
        end
        uscp_pkg::MODE_BLOCK: begin
          w.spi_valid       = 1'b1;
          w.spi_byte        = rx;
          w.reply_valid     = 1'b1;
          w.reply_byte      = fr;
          parser.bytes_left = parser.bytes_left - 16'h0001;
          if (parser.bytes_left == 16'h0000) parser.mode = uscp_pkg::MODE_IDLE;
        end
        default: begin
          parser.mode   = uscp_pkg::MODE_IDLE;
          w.reply_valid = 1'b1;
          w.reply_byte  = uscp_pkg::BYTE_ACK;
          case (rx)
            uscp_pkg::CMD_IDENT:     w.reply_byte = uscp_pkg::BYTE_IDENT;
            uscp_pkg::CMD_RESET_LO:  parser.reset_reg = 1'b0;
            uscp_pkg::CMD_RESET_HI:  parser.reset_reg = 1'b1;
            uscp_pkg::CMD_SELECT_LO: parser.select_reg = 1'b0;
            uscp_pkg::CMD_SELECT_HI: parser.select_reg = 1'b1;
            uscp_pkg::CMD_WREN: begin
              w.spi_valid       = 1'b1;
              w.spi_byte        = uscp_pkg::SPI_WREN;
              w.spi_framed      = 1'b1;
              parser.select_reg = 1'b1;
            end
            uscp_pkg::CMD_SINGLE: begin
              w.reply_valid = 1'b0;
              w.reply_byte  = 8'h00;
              parser.mode   = uscp_pkg::MODE_SINGLE;
            end
            uscp_pkg::CMD_BLOCK: begin
              w.reply_valid = 1'b0;
              w.reply_byte  = 8'h00;
              parser.mode   = uscp_pkg::MODE_LEN_LO;
            end
            default:       w.reply_byte = uscp_pkg::BYTE_NAK;
          endcase
        end
      endcase
      w.select_level = parser.select_reg;
      w.reset_level  = parser.reset_reg;
      return w;
    endfunction

    function void note_command(logic [7:0] rx, logic [7:0] fr);
      expected_words.push_back(predict_word(rx, fr));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_word(uscp_pkg::result_t got);
      uscp_pkg::result_t want;
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      check_field("reply_valid", 8'(got.reply_valid), 8'(want.reply_valid));
      check_field("reply_byte", got.reply_byte, want.reply_byte);
      check_field("spi_valid", 8'(got.spi_valid), 8'(want.spi_valid));
      check_field("spi_byte", got.spi_byte, want.spi_byte);
      check_field("spi_framed", 8'(got.spi_framed), 8'(want.spi_framed));
      check_field("select_level", 8'(got.select_level), 8'(want.select_level));
      check_field("reset_level", 8'(got.reset_level), 8'(want.reset_level));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  // stall control shared by both sides; cleared for one long stretch
  logic gaps_on = 1'b1;
  int   words_sent = 0;

  bridge_tracker tracker = new();

  uscp_in_if  cmd_if ();
  uscp_out_if rsp_if ();

  uart_spi_bridge_command_parser i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  always #10 clk = ~clk;

  // run limit, far above the slowest correct run
  initial begin
    #(60_000_000);
    $display("Some tests failed");
    $finish;
  end

  // offers one command word, idling first at random; valid is written once
  // per time step, so a word that follows straight on keeps valid high
  task automatic send_command(input logic [7:0] rx, input logic [7:0] fr);
    while (gaps_on && $urandom_range(99) < 35) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.rx_byte     <= rx;
    cmd_if.flash_reply <= fr;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    // word taken at this edge
    tracker.note_command(rx, fr);
    words_sent++;
  endtask

  // length-prefixed block: command, low and high length bytes, then data
  task automatic send_block(input int unsigned len);
    send_command(uscp_pkg::CMD_BLOCK, 8'($urandom_range(255)));
    send_command(len[7:0], 8'($urandom_range(255)));
    send_command(len[15:8], 8'($urandom_range(255)));
    for (int unsigned i = 0; i < len; i++)
      send_command(8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // result side: sample the handshake at the edge, then pick the next ready
  initial begin
    uscp_pkg::result_t got;
    rsp_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        got.reply_valid  = rsp_if.reply_valid;
        got.reply_byte   = rsp_if.reply_byte;
        got.spi_valid    = rsp_if.spi_valid;
        got.spi_byte     = rsp_if.spi_byte;
        got.spi_framed   = rsp_if.spi_framed;
        got.select_level = rsp_if.select_level;
        got.reset_level  = rsp_if.reset_level;
        tracker.check_word(got);
      end
      rsp_if.ready <= !(gaps_on && $urandom_range(99) < 35);
    end
  end

  // stimulus
  initial begin
    logic [7:0] simple_cmds[6];
    logic [7:0] opening[$];
    int unsigned pick;
    int unsigned len;

    simple_cmds = '{uscp_pkg::CMD_IDENT, uscp_pkg::CMD_RESET_LO, uscp_pkg::CMD_RESET_HI,
                    uscp_pkg::CMD_SELECT_LO, uscp_pkg::CMD_SELECT_HI, uscp_pkg::CMD_WREN};
    // single-byte commands, both extremes of the unknown bytes, and a
    // write-enable issued while chip select is held low
    opening = {uscp_pkg::CMD_IDENT, 8'h00, 8'hFF, uscp_pkg::CMD_RESET_LO,
               uscp_pkg::CMD_RESET_HI, uscp_pkg::CMD_SELECT_LO, uscp_pkg::CMD_WREN,
               uscp_pkg::CMD_SELECT_LO, uscp_pkg::CMD_SELECT_HI};

    rst                <= 1'b1;
    cmd_if.valid       <= 1'b0;
    cmd_if.rx_byte     <= 8'h00;
    cmd_if.flash_reply <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (opening[i]) send_command(opening[i], 8'hFF);
    // single transfers with the data and flash byte extremes
    send_command(uscp_pkg::CMD_SINGLE, 8'h00);
    send_command(8'hFF, 8'h00);
    send_command(uscp_pkg::CMD_SINGLE, 8'hFF);
    send_command(8'h00, 8'hFF);
    // zero-length block goes straight back to idle
    send_block(0);
    // short block whose data looks like commands
    send_command(uscp_pkg::CMD_BLOCK, 8'h00);
    send_command(8'h02, 8'h00);
    send_command(8'h00, 8'h00);
    send_command(uscp_pkg::CMD_IDENT, 8'hA5);
    send_command(uscp_pkg::CMD_BLOCK, 8'h5A);
    // fpga reset held low going into the random part
    send_command(uscp_pkg::CMD_RESET_LO, 8'h00);

    // random part: mostly well-formed sequences, some noise
    while (words_sent < 1050) begin
      gaps_on = !(words_sent >= 400 && words_sent < 600);
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_command(simple_cmds[$urandom_range(5)], 8'($urandom_range(255)));
      end else if (pick < 55) begin
        send_command(uscp_pkg::CMD_SINGLE, 8'($urandom_range(255)));
        send_command(8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (pick < 85) begin
        // mostly short blocks, now and then empty or longer
        len = $urandom_range(99);
        if (len < 10)      len = 0;
        else if (len < 85) len = $urandom_range(8, 1);
        else if (len < 97) len = $urandom_range(40, 9);
        else               len = $urandom_range(300, 256);
        send_block(len);
      end else begin
        // noise: any byte at all, may start a transfer that eats what follows
        send_command(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
    gaps_on = 1'b1;

    // drop valid at the edge that took the last word
    cmd_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    // keep the clock running to catch any stray result word
    repeat (5) @(posedge clk);

    if (tracker.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
